FILE: design/rle_rgba_pixel_decoder_top_defines.svh
// Assertion helpers for the RLE pixel decoder.
`ifndef RLE_RGBA_PIXEL_DECODER_TOP_DEFINES_SVH
`define RLE_RGBA_PIXEL_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RLEPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RLEPD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rlepd_pkg.sv
`default_nettype none

package rlepd_pkg;

	localparam logic [16:0] FRAME_PIXELS_RST = 17'd23040;
	localparam int unsigned CQ_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVERRUN = 2'd1,
		ST_TRUNC   = 2'd2,
		ST_SHORT   = 2'd3
	} status_t;

	// At most one command per accepted byte: a run, a literal pixel or a status-only close.
	typedef struct packed {
		logic [31:0] pixel;
		logic [7:0]  count;
		logic        frame_end;
		status_t     status;
	} cmd_t;

endpackage

`default_nettype wire

FILE: design/rlepd_front.sv
`default_nettype none

module rlepd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [16:0]   frame_pixels,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    data_byte,
	input  wire logic          last_byte,
	input  wire logic          q_full,
	output logic               q_push,
	output rlepd_pkg::cmd_t    q_cmd
);
	import rlepd_pkg::*;

	logic        err_q, err_n;
	logic        inpk_q, inpk_n;
	logic        run_q, run_n;
	logic [7:0]  left_q, left_n;
	logic [1:0]  bip_q, bip_n;
	logic [23:0] part_q, part_n;
	logic [16:0] pw_q, pw_n;

	logic        accept;
	logic [7:0]  hdr_count;
	logic [17:0] hdr_sum;
	logic        cmd_vld;
	cmd_t        cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign hdr_count = {1'b0, data_byte[6:0]} + 8'd1;
	assign hdr_sum   = {1'b0, pw_q} + {10'd0, hdr_count};

	always_comb begin
		err_n   = err_q;
		inpk_n  = inpk_q;
		run_n   = run_q;
		left_n  = left_q;
		bip_n   = bip_q;
		part_n  = part_q;
		pw_n    = pw_q;
		cmd_vld = 1'b0;
		cmd     = '0;
		if (!err_q) begin
			if (!inpk_q) begin
				if (hdr_sum > {1'b0, frame_pixels}) begin
					err_n = 1'b1;
				end else begin
					inpk_n = 1'b1;
					run_n  = data_byte[7];
					left_n = hdr_count;
					bip_n  = 2'd0;
					part_n = '0;
				end
			end else if (bip_q != 2'd3) begin
				case (bip_q)
					2'd0: part_n[7:0]   = data_byte;
					2'd1: part_n[15:8]  = data_byte;
					default: part_n[23:16] = data_byte;
				endcase
				bip_n = bip_q + 2'd1;
			end else begin
				cmd_vld   = 1'b1;
				cmd.pixel = {data_byte, part_q};
				bip_n     = 2'd0;
				part_n    = '0;
				if (run_q) begin
					cmd.count = left_q;
					pw_n      = pw_q + {9'd0, left_q};
					left_n    = 8'd0;
					inpk_n    = 1'b0;
				end else begin
					cmd.count = 8'd1;
					pw_n      = pw_q + 17'd1;
					left_n    = left_q - 8'd1;
					inpk_n    = (left_q != 8'd1);
				end
			end
		end
		if (last_byte) begin
			cmd_vld       = 1'b1;
			cmd.frame_end = 1'b1;
			if (err_n) begin
				cmd.status = ST_OVERRUN;
			end else if (inpk_n) begin
				cmd.status = ST_TRUNC;
			end else if (pw_n != frame_pixels) begin
				cmd.status = ST_SHORT;
			end else begin
				cmd.status = ST_OK;
			end
			err_n  = 1'b0;
			inpk_n = 1'b0;
			run_n  = 1'b0;
			left_n = 8'd0;
			bip_n  = 2'd0;
			part_n = '0;
			pw_n   = '0;
		end
	end

	assign q_push = accept && cmd_vld;
	assign q_cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q  <= 1'b0;
			inpk_q <= 1'b0;
			run_q  <= 1'b0;
			left_q <= '0;
			bip_q  <= '0;
			part_q <= '0;
			pw_q   <= '0;
		end else if (accept) begin
			err_q  <= err_n;
			inpk_q <= inpk_n;
			run_q  <= run_n;
			left_q <= left_n;
			bip_q  <= bip_n;
			part_q <= part_n;
			pw_q   <= pw_n;
		end
	end

endmodule

`default_nettype wire

FILE: design/rlepd_cmdq.sv
`default_nettype none

module rlepd_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  rlepd_pkg::cmd_t    push_cmd,
	output logic               full,
	output logic               head_valid,
	output rlepd_pkg::cmd_t    head_cmd,
	input  wire logic          pop
);
	import rlepd_pkg::*;

	localparam int unsigned PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int unsigned CW = $clog2(CQ_DEPTH + 1);

	cmd_t          mem_q [CQ_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(CQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(CQ_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(CQ_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/rlepd_back.sv
`default_nettype none

module rlepd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  rlepd_pkg::cmd_t    q_cmd,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [31:0]        pixel_first,
	output logic [31:0]        pixel_second,
	output logic [1:0]         beat_pixels,
	output logic               frame_end,
	output logic [1:0]         status
);
	import rlepd_pkg::*;

	logic [7:0]  sent_q;
	logic        ovld_q;
	logic [31:0] pf_q;
	logic [31:0] ps_q;
	logic [1:0]  pc_q;
	logic        fe_q;
	logic [1:0]  st_q;

	logic [7:0]  remain;
	logic [1:0]  n;
	logic        final_beat;
	logic        emit;

	assign remain     = q_cmd.count - sent_q;
	assign n          = (remain >= 8'd2) ? 2'd2 : remain[1:0];
	assign final_beat = (remain <= 8'd2);
	assign emit       = q_valid && (!ovld_q || out_ready);
	assign q_pop      = emit && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (emit) begin
				sent_q <= final_beat ? 8'd0 : sent_q + 8'd2;
				ovld_q <= 1'b1;
			end else if (out_ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pf_q <= (n != 2'd0) ? q_cmd.pixel : 32'd0;
			ps_q <= (n == 2'd2) ? q_cmd.pixel : 32'd0;
			pc_q <= n;
			fe_q <= q_cmd.frame_end && final_beat;
			st_q <= (q_cmd.frame_end && final_beat) ? q_cmd.status : ST_OK;
		end
	end

	assign out_valid    = ovld_q;
	assign pixel_first  = pf_q;
	assign pixel_second = ps_q;
	assign beat_pixels  = pc_q;
	assign frame_end    = fe_q;
	assign status       = st_q;

endmodule

`default_nettype wire

FILE: design/rle_rgba_pixel_decoder_top.sv
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | data_byte, last_byte
// out      | out_valid / out_ready| pixel_first, pixel_second, beat_pixels,
//          |                      | frame_end, status
// cfg      | cfg_valid / cfg_ready| cfg_data (frame_pixels)
//
// One input beat per cycle while the two-entry command queue has room.
// A run of n pixels leaves as ceil(n/2) output beats, one per cycle while
// out_ready is high; every other byte gives at most one beat. Input stalls
// once the queue is full. Reset clears all frame state; frame_pixels
// returns to 23040. cfg_ready is always high.
`default_nettype none
`include "rle_rgba_pixel_decoder_top_defines.svh"

module rle_rgba_pixel_decoder_top #(
	parameter int unsigned MAX_FRAME_PIXELS = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [16:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      pixel_first,
	output logic [31:0]      pixel_second,
	output logic [1:0]       beat_pixels,
	output logic             frame_end,
	output logic [1:0]       status
);
	import rlepd_pkg::*;

	localparam int unsigned FP_CAP   = (MAX_FRAME_PIXELS > 131071) ? 131071 : MAX_FRAME_PIXELS;
	localparam logic [16:0] FP_CAP_W = 17'(FP_CAP);

	logic [16:0] frame_pixels_q;
	logic        q_push;
	cmd_t        q_push_cmd;
	logic        q_full;
	logic        q_valid;
	cmd_t        q_head;
	logic        q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= FRAME_PIXELS_RST;
		end else if (cfg_valid) begin
			frame_pixels_q <= (cfg_data > FP_CAP_W) ? FP_CAP_W : cfg_data;
		end
	end

	rlepd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_pixels (frame_pixels_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_push_cmd)
	);

	rlepd_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.full       (q_full),
		.head_valid (q_valid),
		.head_cmd   (q_head),
		.pop        (q_pop)
	);

	rlepd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.beat_pixels  (beat_pixels),
		.frame_end    (frame_end),
		.status       (status)
	);

	`RLEPD_ASSERT_IMP(a_empty_beat_ends_frame, out_valid && (beat_pixels == 2'd0), frame_end, "status-only beat without frame_end")
	`RLEPD_ASSERT_IMP(a_status_only_at_end, out_valid && (status != ST_OK), frame_end, "status set off frame_end")
	`RLEPD_ASSERT_IMP(a_full_has_head, q_full, q_valid, "queue full but empty")
	`RLEPD_ASSERT_NXT(a_pop_frees_slot, q_pop && !q_push, !q_full, "queue still full after pop")

endmodule

`default_nettype wire

FILE: sim/rle_rgba_pixel_decoder_top_tb.sv
`timescale 1ns / 1ps

module rle_rgba_pixel_decoder_top_tb;
	import rlepd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned CFG_SETTLE   = 16;
	localparam int unsigned TAIL_CYCLES  = 40;
	localparam int unsigned RANDOM_ITEMS = 200;
	localparam int unsigned SAT_PIXELS   = 65536;

	typedef enum int {FR_EXACT, FR_SHORT, FR_OVER, FR_TRUNC, FR_NOISE} frame_kind_t;

	typedef struct packed {
		logic [31:0] pix0;
		logic [31:0] pix1;
		logic [1:0]  count;
		logic        frame_end;
		status_t     status;
	} pixel_beat_t;

	class rle_frame_tracker;
		int unsigned frame_pixels;
		bit          in_packet;
		bit          run_packet;
		int unsigned pixels_left;
		int unsigned byte_in_pixel;
		int unsigned pixels_written;
		logic [23:0] partial_pixel;
		status_t     err_status;
		pixel_beat_t pending_beats[$];
		int          errors;

		function new();
			frame_pixels = FRAME_PIXELS_RST;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			in_packet = 0;
			run_packet = 0;
			pixels_left = 0;
			byte_in_pixel = 0;
			pixels_written = 0;
			partial_pixel = '0;
			err_status = ST_OK;
		endfunction

		function void set_frame_pixels(logic [16:0] v);
			frame_pixels = (v > SAT_PIXELS) ? SAT_PIXELS : v;
		endfunction

		function pixel_beat_t beat_of(logic [31:0] p0, logic [31:0] p1, int unsigned n);
			pixel_beat_t bt;
			bt.pix0 = p0;
			bt.pix1 = (n >= 2) ? p1 : '0;
			bt.count = 2'(n);
			bt.frame_end = 1'b0;
			bt.status = ST_OK;
			return bt;
		endfunction

		function void take_byte(logic [7:0] b, logic lst);
			pixel_beat_t beats[$];
			logic [31:0] px;
			int unsigned n;
			status_t     st;
			if (err_status == ST_OK) begin
				if (!in_packet) begin
					n = b[6:0] + 1;
					if (pixels_written + n > frame_pixels) begin
						err_status = ST_OVERRUN;
					end else begin
						in_packet = 1;
						run_packet = b[7];
						pixels_left = n;
						byte_in_pixel = 0;
						partial_pixel = '0;
					end
				end else if (byte_in_pixel < 3) begin
					partial_pixel[8*byte_in_pixel +: 8] = b;
					byte_in_pixel++;
				end else begin
					px = {b, partial_pixel};
					byte_in_pixel = 0;
					partial_pixel = '0;
					if (run_packet) begin
						while (pixels_left > 0) begin
							n = (pixels_left >= 2) ? 2 : 1;
							beats.push_back(beat_of(px, px, n));
							pixels_left -= n;
							pixels_written += n;
						end
						in_packet = 0;
					end else begin
						beats.push_back(beat_of(px, '0, 1));
						pixels_written++;
						if (pixels_left > 0)
							pixels_left--;
						if (pixels_left == 0)
							in_packet = 0;
					end
				end
			end
			if (lst) begin
				if (err_status != ST_OK)
					st = err_status;
				else if (in_packet)
					st = ST_TRUNC;
				else if (pixels_written != frame_pixels)
					st = ST_SHORT;
				else
					st = ST_OK;
				if (beats.size() == 0)
					beats.push_back(beat_of('0, '0, 0));
				beats[beats.size()-1].frame_end = 1'b1;
				beats[beats.size()-1].status = st;
				clear_frame();
			end
			foreach (beats[i])
				pending_beats.push_back(beats[i]);
		endfunction

		function void check_beat(logic [31:0] p0, logic [31:0] p1, logic [1:0] cnt,
				logic fe, logic [1:0] st);
			pixel_beat_t want;
			if (pending_beats.size() == 0) begin
				$error("unexpected output beat: pixel_first %h beat_pixels %0d", p0, cnt);
				errors++;
				return;
			end
			want = pending_beats.pop_front();
			if (p0 !== want.pix0) begin
				$error("pixel_first: expected %h, got %h", want.pix0, p0);
				errors++;
			end
			if (p1 !== want.pix1) begin
				$error("pixel_second: expected %h, got %h", want.pix1, p1);
				errors++;
			end
			if (cnt !== want.count) begin
				$error("beat_pixels: expected %0d, got %0d", want.count, cnt);
				errors++;
			end
			if (fe !== want.frame_end) begin
				$error("frame_end: expected %0d, got %0d", want.frame_end, fe);
				errors++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				errors++;
			end
		endfunction

		function int pending();
			return pending_beats.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [16:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] pixel_first;
	logic [31:0] pixel_second;
	logic [1:0]  beat_pixels;
	logic        frame_end;
	logic [1:0]  status;

	rle_frame_tracker frames = new();
	logic [7:0]       frame_bytes[$];
	bit               steady;
	int unsigned      hold_cycles;
	int unsigned      items_sent;
	int unsigned      cycle_count;

	rle_rgba_pixel_decoder_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.beat_pixels  (beat_pixels),
		.frame_end    (frame_end),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				frames.set_frame_pixels(cfg_data);
			if (in_valid && in_ready)
				frames.take_byte(data_byte, last_byte);
			if (out_valid && out_ready)
				frames.check_beat(pixel_first, pixel_second, beat_pixels, frame_end, status);
		end
	end

	// receiver: random stalls, or a counted hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 32);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic lst);
		while (!steady && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_frame_pixels(input logic [16:0] v);
		wait_drain();
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void add_packet(int unsigned n, bit run);
		frame_bytes.push_back({run, 7'(n - 1)});
		repeat (run ? 4 : 4 * n) frame_bytes.push_back(8'($urandom));
	endfunction

	function automatic void fill_pixels(int unsigned target);
		int unsigned n;
		bit          run;
		while (target > 0) begin
			if ($urandom_range(1))
				n = $urandom_range(1, (target < 6) ? target : 6);
			else
				n = $urandom_range(1, (target < 128) ? target : 128);
			run = (n > 6) || ($urandom_range(1) == 1);
			add_packet(n, run);
			target -= n;
		end
	endfunction

	function automatic void build_frame(frame_kind_t kind);
		int unsigned fp;
		int unsigned done;
		int unsigned cut;
		frame_bytes.delete();
		fp = frames.frame_pixels;
		if (fp > 600 && (kind == FR_EXACT || kind == FR_OVER))
			kind = FR_SHORT;
		case (kind)
			FR_EXACT: fill_pixels(fp);
			FR_SHORT: fill_pixels((fp > 1) ? $urandom_range(1, (fp > 600) ? 300 : fp - 1) : 1);
			FR_OVER: begin
				done = (fp > 127) ? $urandom_range(fp - 127, fp) : $urandom_range(0, fp);
				fill_pixels(done);
				add_packet($urandom_range(fp - done + 1, 128), $urandom_range(1));
				repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom));
			end
			FR_TRUNC: begin
				fill_pixels((fp == 0) ? 1 : ((fp > 300) ? 300 : fp));
				cut = $urandom_range(1, frame_bytes.size() - 1);
				while (frame_bytes.size() > cut)
					void'(frame_bytes.pop_back());
			end
			default: repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
		endcase
	endfunction

	initial begin
		int unsigned random_goal;
		int unsigned phase;
		logic [16:0] fp;
		frame_kind_t kind;

		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		data_byte   <= '0;
		last_byte   <= 1'b0;
		steady      = 1'b0;
		hold_cycles = 0;
		items_sent  = 0;
		cycle_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame size: a full 128-pixel run as one frame, then a frame of a lone header
		frame_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h5A, 8'hA5};
		send_frame();
		frame_bytes = '{8'h00};
		send_frame();

		// zero frame size: every header overruns
		write_frame_pixels(17'd0);
		frame_bytes = '{8'h80};
		send_frame();

		// one pixel: exact run, exact literal, overrun with ignored tail
		write_frame_pixels(17'd1);
		frame_bytes = '{8'h80, 8'h01, 8'h80, 8'h7F, 8'hFE};
		send_frame();
		frame_bytes = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_frame();
		frame_bytes = '{8'h81, 8'h33, 8'h44};
		send_frame();

		// above the maximum saturates; literal pixel on the last byte, packet open
		write_frame_pixels(17'h1FFFF);
		frame_bytes = '{8'h7F, 8'h10, 8'h20, 8'h30, 8'h40};
		send_frame();

		random_goal = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < random_goal) begin
			phase++;
			if (phase == 2) begin
				// long receiver hold-off while runs keep arriving
				write_frame_pixels(17'd512);
				hold_cycles = 300;
				frame_bytes.delete();
				repeat (4) add_packet(128, 1'b1);
				send_frame();
				wait_drain();
			end
			case ($urandom_range(9))
				0: fp = 17'd1;
				1: fp = 17'd0;
				2: fp = 17'd65536;
				3: fp = 17'($urandom_range(65537, 131071));
				4: fp = 17'($urandom_range(100, 400));
				default: fp = 17'($urandom_range(2, 40));
			endcase
			write_frame_pixels(fp);
			steady = (phase == 1);
			repeat ($urandom_range(2, 6)) begin
				if (items_sent < random_goal) begin
					case ($urandom_range(9))
						5: kind = FR_SHORT;
						6: kind = FR_OVER;
						7: kind = FR_TRUNC;
						8: kind = FR_NOISE;
						default: kind = FR_EXACT;
					endcase
					build_frame(kind);
					send_frame();
					if ($urandom_range(7) == 0)
						wait_drain();
				end
			end
			steady = 1'b0;
		end

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (frames.errors == 0 && frames.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
